>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge, quiet while reset is asserted.
`define M3H_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define M3H_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/m3h_pkg.sv
package m3h_pkg;

	localparam logic [31:0] C1       = 32'hcc9e2d51;
	localparam logic [31:0] C2       = 32'h1b873593;
	localparam logic [31:0] BODY_ADD = 32'he6546b64;
	localparam logic [31:0] F1       = 32'h85ebca6b;
	localparam logic [31:0] F2       = 32'hc2b2ae35;

	localparam logic [2:0] BYTES_PER_WORD = 3'd4;

	// One scrambled word on its way from the front to the back.
	typedef struct packed {
		logic [31:0] k;
		logic [2:0]  count;
		logic        last;
	} m3h_item_t;

	typedef struct packed {
		logic      valid;
		m3h_item_t item;
	} m3h_push_t;

endpackage

>>> rtl/m3h_in_if.sv
interface m3h_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        last_word;

	modport source (output valid, data_word, byte_count, last_word, input ready);
	modport sink (input valid, data_word, byte_count, last_word, output ready);
endinterface

>>> rtl/m3h_out_if.sv
interface m3h_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] hash_value;

	modport source (output valid, hash_value, input ready);
	modport sink (input valid, hash_value, output ready);
endinterface

>>> rtl/m3h_cfg_if.sv
interface m3h_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> rtl/m3h_front.sv
module m3h_front import m3h_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	m3h_in_if.sink    msg,
	output m3h_push_t push,
	input  logic      q_ready
);

	logic        v_s1, v_s2;
	logic [31:0] m_s1, k_s2;
	logic [2:0]  cnt_s1, cnt_s2;
	logic        last_s1, last_s2;
	logic        en_s1, en_s2;
	logic [2:0]  cnt_in;
	logic [31:0] word_in;
	logic [31:0] rot_s1;

	assign en_s2     = !v_s2 || q_ready;
	assign en_s1     = !v_s1 || en_s2;
	assign msg.ready = en_s1;

	// non-last words always count as full
	always_comb begin
		if (!msg.last_word || msg.byte_count > BYTES_PER_WORD) begin
			cnt_in = BYTES_PER_WORD;
		end else begin
			cnt_in = msg.byte_count;
		end
	end

	// drop bytes past the tail
	always_comb begin
		case (cnt_in)
			3'd1: word_in = {24'd0, msg.data_word[7:0]};
			3'd2: word_in = {16'd0, msg.data_word[15:0]};
			3'd3: word_in = {8'd0, msg.data_word[23:0]};
			default: word_in = msg.data_word;
		endcase
	end

	assign rot_s1 = {m_s1[16:0], m_s1[31:17]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= msg.valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			m_s1    <= word_in * C1;
			cnt_s1  <= cnt_in;
			last_s1 <= msg.last_word;
		end
		if (en_s2) begin
			k_s2    <= rot_s1 * C2;
			cnt_s2  <= cnt_s1;
			last_s2 <= last_s1;
		end
	end

	assign push.valid      = v_s2;
	assign push.item.k     = k_s2;
	assign push.item.count = cnt_s2;
	assign push.item.last  = last_s2;

endmodule

>>> rtl/m3h_queue.sv
module m3h_queue import m3h_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  m3h_push_t push,
	output logic      in_ready,
	output logic      out_valid,
	output m3h_item_t out_item,
	input  logic      out_ready
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	m3h_item_t       mem_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign in_ready  = cnt_q != CW'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign do_push   = push.valid && in_ready;
	assign do_pop    = out_valid && out_ready;
	assign out_item  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push.item;
	end

endmodule

>>> rtl/m3h_back.sv
module m3h_back import m3h_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] seed,
	input  logic        q_valid,
	input  m3h_item_t   q_item,
	output logic        q_ready,
	m3h_out_if.source   hash
);

	logic        in_msg_q;
	logic [31:0] h_q, len_q;
	logic [31:0] h_base, len_base, h_fold, h_tail, len_fin, x_fin;
	logic        pop;

	logic        v_s1, v_s2, v_s3, out_v_q;
	logic [31:0] d_s1, d_s2, d_s3, out_d_q;
	logic        en_s1, en_s2, en_s3, en_out;
	logic [31:0] t_s2, rot_fold, xk;

	assign en_out  = !out_v_q || hash.ready;
	assign en_s3   = !v_s3 || en_out;
	assign en_s2   = !v_s2 || en_s3;
	assign en_s1   = !v_s1 || en_s2;
	assign q_ready = en_s1;
	assign pop     = q_valid && en_s1;

	// first word of a message starts from the seed
	assign h_base   = in_msg_q ? h_q : seed;
	assign len_base = in_msg_q ? len_q : '0;

	// body step: xor, rotl 13, times 5 plus constant
	assign xk       = h_base ^ q_item.k;
	assign rot_fold = {xk[18:0], xk[31:19]};
	assign h_fold   = {rot_fold[29:0], 2'b00} + rot_fold + BODY_ADD;

	always_comb begin
		if (q_item.count == BYTES_PER_WORD) begin
			h_tail = h_fold;
		end else if (q_item.count != 3'd0) begin
			h_tail = xk;
		end else begin
			h_tail = h_base;
		end
	end

	assign len_fin = len_base + {29'd0, q_item.count};
	assign x_fin   = h_tail ^ len_fin;
	assign t_s2    = d_s2 ^ {13'd0, d_s2[31:13]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (pop) in_msg_q <= !q_item.last;
			if (en_s1)  v_s1    <= pop && q_item.last;
			if (en_s2)  v_s2    <= v_s1;
			if (en_s3)  v_s3    <= v_s2;
			if (en_out) out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !q_item.last) begin
			h_q   <= h_fold;
			len_q <= len_base + 32'd4;
		end
		if (en_s1)  d_s1    <= x_fin ^ {16'd0, x_fin[31:16]};
		if (en_s2)  d_s2    <= d_s1 * F1;
		if (en_s3)  d_s3    <= t_s2 * F2;
		if (en_out) out_d_q <= d_s3 ^ {16'd0, d_s3[31:16]};
	end

	assign hash.valid      = out_v_q;
	assign hash.hash_value = out_d_q;

endmodule

>>> rtl/murmur3_hash_32_top.sv
// channel  dir  payload                               transfer
// cfg      in   data (seed, 32b)                      valid & ready, ready always high
// msg      in   data_word, byte_count, last_word      valid & ready
// hash     out  hash_value                            valid & ready, one per last word
//
// Sustains one word per cycle while hash is not stalled; the running hash (xor, rotl 13,
// x5 plus constant) closes combinationally in the back end. A last word goes to the hash
// via two scramble multiplies, the queue, three finalizer stages and the output register.
// Reset clears the seed to zero and empties every stage; no clearing pass.
// A stalled hash output backs up the finalizer, then the queue, then msg.ready.
`include "assert_macros.svh"

module murmur3_hash_32_top import m3h_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	m3h_cfg_if.sink   cfg,
	m3h_in_if.sink    msg,
	m3h_out_if.source hash
);

	logic [31:0] seed_q;
	m3h_push_t   push;
	logic        q_in_ready;
	logic        q_out_valid;
	m3h_item_t   q_out_item;
	logic        q_out_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg.valid) begin
			seed_q <= cfg.data;
		end
	end

	m3h_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.msg     (msg),
		.push    (push),
		.q_ready (q_in_ready)
	);

	m3h_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_ready  (q_in_ready),
		.out_valid (q_out_valid),
		.out_item  (q_out_item),
		.out_ready (q_out_ready)
	);

	m3h_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.seed    (seed_q),
		.q_valid (q_out_valid),
		.q_item  (q_out_item),
		.q_ready (q_out_ready),
		.hash    (hash)
	);

	`M3H_ASSERT_ALWAYS(a_no_hash_in_reset, !arst_n |-> !hash.valid, "hash valid during reset")
	`M3H_ASSERT(a_front_hold, push.valid && !q_in_ready |=> push.valid && $stable(push.item), "front dropped a stalled word")
	`M3H_ASSERT(a_back_hold, q_out_valid && !q_out_ready |=> q_out_valid && $stable(q_out_item), "queue head changed under stall")

endmodule
